// File: rtl/dts_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the deadline task scheduler.
// No dependencies.
package dts_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam logic [3:0] NO_TASK = 4'd8;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TASK_COUNT = 3'd0,
        REG_POLICY     = 3'd1,
        REG_PERIOD     = 3'd2,
        REG_COST       = 3'd3,
        REG_SCHED_LEN  = 3'd4
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SWEEP  = 5'b00100,
        S_COMMIT = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    typedef struct packed {
        logic [7:0] phase;
        logic [7:0] work;
    } entry_t;

    typedef struct packed {
        logic [15:0] tick_index;
        logic        done_res;
        logic        deadline_miss;
        logic        busy_res;
        logic [2:0]  ran_task;
    } result_t;

    function automatic logic [7:0] table_byte(input logic [63:0] tbl, input logic [2:0] k);
        table_byte = tbl[8*k +: 8];
    endfunction

endpackage

// File: rtl/deadline_task_scheduler.sv
`timescale 1ns / 1ps
// Deadline task scheduler top level: EDF/LLF selection over a per-task state memory.
// Depends on dts_pkg.
//
//  channel | ports                         | beat contents (low bit first)
//  --------+-------------------------------+-----------------------------------------------
//  input   | s_tvalid s_tready s_tdata[7:0]| restart
//  result  | m_tvalid m_tready m_tdata[23:0]| ran_task, busy_res, deadline_miss, done_res, tick_index
//  config  | cfg_wr_en cfg_addr cfg_wdata  | register index, data
//
// A tick steps through take beat, check, one sweep step per task in use
// through the single read port of the task memory, commit, result load.
// A halted, finished or taskless tick skips sweep and commit. Reset clears valid flags of all
// entries at once; no clearing pass. One input beat is buffered while a tick runs, and a
// finished result waits in the output register; the engine stalls only at result load.
module deadline_task_scheduler
    import dts_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [2:0] ran_task, [3] busy_res,
                                             // [4] deadline_miss, [5] done_res,
                                             // [21:6] tick_index
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    logic [3:0]  task_count_reg;
    logic        policy_reg;
    logic [63:0] period_reg;
    logic [63:0] cost_reg;
    logic [15:0] sched_len_reg;

    state_t state_reg, state_next;

    logic              in_full_reg;
    logic              in_restart_reg;
    logic              pop;

    logic [3:0]        running_reg;
    logic              halted_reg;
    logic [15:0]       time_reg;

    logic [MAX_TASKS-1:0] entry_valid_reg;
    entry_t            mem [0:MAX_TASKS-1];
    entry_t            rd_data_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;

    logic [IDX_W-1:0]  proc_idx_reg;
    logic              best_vld_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic signed [9:0] best_key_reg;
    logic [7:0]        best_work_reg;
    logic [7:0]        best_phase_reg;
    logic              miss_reg;

    result_t           res_reg;
    logic              m_tvalid_reg;
    result_t           m_data_reg;

    logic [CNT_W-1:0]  n_eff;
    logic              last_entry;
    logic              is_done;
    logic              out_free;

    logic [7:0]        cur_phase, cur_work, per, cost, work_rel, phase_adv, best_work_dec;
    logic              entry_miss, take;
    logic signed [9:0] key_base, key;

    assign n_eff = (task_count_reg > 4'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                    : CNT_W'(task_count_reg);
    assign last_entry = (CNT_W'(proc_idx_reg) + CNT_W'(1)) == n_eff;
    assign is_done    = halted_reg || (time_reg >= sched_len_reg);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign pop        = (state_reg == S_IDLE) && in_full_reg;
    assign s_tready   = !in_full_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    // per-entry release, phase advance and key
    always_comb begin
        cur_phase  = rd_valid_reg ? rd_data_reg.phase : 8'd0;
        cur_work   = rd_valid_reg ? rd_data_reg.work  : 8'd0;
        per        = table_byte(period_reg, 3'(proc_idx_reg));
        cost       = table_byte(cost_reg, 3'(proc_idx_reg));
        entry_miss = (cur_phase == 8'd0) && (cur_work != 8'd0);
        work_rel   = (cur_phase == 8'd0) ? cost : cur_work;
        phase_adv  = (cur_phase >= per) ? 8'd0 : cur_phase + 8'd1;
        key_base   = $signed({2'b00, per}) + 10'sd1 - $signed({2'b00, cur_phase});
        key        = policy_reg ? key_base - $signed({2'b00, work_rel}) : key_base;
        take       = (work_rel != 8'd0) &&
                     (!best_vld_reg || key < best_key_reg ||
                      (key == best_key_reg && 4'(proc_idx_reg) == running_reg));
        best_work_dec = best_work_reg - 8'd1;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_full_reg) state_next = S_CHECK;
            S_CHECK:  state_next = (is_done || n_eff == '0) ? S_OUT : S_SWEEP;
            S_SWEEP:  if (last_entry) state_next = S_COMMIT;
            S_COMMIT: state_next = S_OUT;
            S_OUT:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // writes during the sweep hit the entry just read, never the next read address;
    // the commit write ends before the next tick issues its first read
    always_comb begin
        rd_addr   = (state_reg == S_SWEEP && !last_entry) ? proc_idx_reg + IDX_W'(1) : '0;
        mem_we    = 1'b0;
        mem_waddr = proc_idx_reg;
        mem_wdata = '{phase: phase_adv, work: work_rel};
        if (state_reg == S_SWEEP) begin
            mem_we = 1'b1;
        end else if (state_reg == S_COMMIT) begin
            mem_we    = !miss_reg && best_vld_reg;
            mem_waddr = best_idx_reg;
            mem_wdata = '{phase: best_phase_reg, work: best_work_dec};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg  <= 4'd3;
            policy_reg      <= 1'b0;
            period_reg      <= '0;
            cost_reg        <= '0;
            sched_len_reg   <= 16'd120;
            state_reg       <= S_IDLE;
            in_full_reg     <= 1'b0;
            running_reg     <= NO_TASK;
            halted_reg      <= 1'b0;
            time_reg        <= '0;
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            best_vld_reg    <= 1'b0;
            miss_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            proc_idx_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_TASK_COUNT: task_count_reg <= cfg_wdata[3:0];
                    REG_POLICY:     policy_reg     <= cfg_wdata[0];
                    REG_PERIOD:     period_reg     <= cfg_wdata;
                    REG_COST:       cost_reg       <= cfg_wdata;
                    REG_SCHED_LEN:  sched_len_reg  <= cfg_wdata[15:0];
                    default: ;
                endcase
            end

            state_reg <= state_next;

            if (s_tvalid && s_tready) begin
                in_full_reg <= 1'b1;
            end else if (pop) begin
                in_full_reg <= 1'b0;
            end

            if (pop && in_restart_reg) begin
                running_reg     <= NO_TASK;
                halted_reg      <= 1'b0;
                time_reg        <= '0;
                entry_valid_reg <= '0;
            end else if (mem_we) begin
                entry_valid_reg[mem_waddr] <= 1'b1;
            end
            rd_valid_reg <= entry_valid_reg[rd_addr];

            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CHECK: begin
                    proc_idx_reg <= '0;
                    best_vld_reg <= 1'b0;
                    miss_reg     <= 1'b0;
                    if (!is_done && n_eff == '0) begin
                        time_reg <= time_reg + 16'd1;
                    end
                end
                S_SWEEP: begin
                    proc_idx_reg <= proc_idx_reg + IDX_W'(1);
                    if (entry_miss) begin
                        miss_reg <= 1'b1;
                    end
                    if (take) begin
                        best_vld_reg <= 1'b1;
                    end
                end
                S_COMMIT: begin
                    time_reg <= time_reg + 16'd1;
                    if (miss_reg) begin
                        halted_reg <= 1'b1;
                    end else if (best_vld_reg) begin
                        running_reg <= (best_work_dec == 8'd0) ? NO_TASK : 4'(best_idx_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_restart_reg <= s_tdata[0];
        end
        if (state_reg == S_SWEEP && take) begin
            best_idx_reg   <= proc_idx_reg;
            best_key_reg   <= key;
            best_work_reg  <= work_rel;
            best_phase_reg <= phase_adv;
        end
        if (state_reg == S_CHECK) begin
            res_reg <= '{tick_index: time_reg, done_res: is_done, deadline_miss: 1'b0,
                         busy_res: 1'b0, ran_task: 3'd0};
        end
        if (state_reg == S_COMMIT) begin
            if (miss_reg) begin
                res_reg.deadline_miss <= 1'b1;
            end else if (best_vld_reg) begin
                res_reg.busy_res <= 1'b1;
                res_reg.ran_task <= 3'(best_idx_reg);
            end
        end
        if (state_reg == S_OUT && out_free) begin
            m_data_reg <= res_reg;
        end
    end

endmodule
